// ----- src/ffd_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame deframer package
// Shared types and constants for the start/end marker deframer with XOR check.
// ----------------------------------------------------------------------------
package ffd_pkg;

    // Number of bytes held in front of the newest byte.
    localparam int KEEP_LEN = 8;

    // Configuration register indexes and width of the index field.
    localparam int       CFG_IDX_W  = 8;
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 8'd1;

    // Reset values of the marker registers.
    localparam logic [7:0] START_MARKER_RESET = 8'hAA;
    localparam logic [7:0] END_MARKER_RESET   = 8'h55;

    // Bit positions within the flag byte.
    localparam int FLAG_WALK = 0;
    localparam int FLAG_SIT  = 1;
    localparam int FLAG_LQR  = 2;

    // One stage of the byte shift line.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } cell_t;

    // One decoded frame.
    typedef struct packed {
        logic signed [15:0] velocity_milli;
        logic signed [15:0] yaw_milli;
        logic [7:0]         walk_speed;
        logic               walk_flag;
        logic               sit_flag;
        logic               lqr_select;
        logic               apply_modes;
    } frame_t;

endpackage

// ----- src/ffd_rx_if.sv -----
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one received serial byte per request.
// ----------------------------------------------------------------------------
interface ffd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- src/ffd_frame_if.sv -----
// ----------------------------------------------------------------------------
// Decoded frame channel
// Valid/ready channel carrying the fields of one decoded frame per request.
// ----------------------------------------------------------------------------
interface ffd_frame_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] velocity_milli;
    logic signed [15:0] yaw_milli;
    logic [7:0]         walk_speed;
    logic               walk_flag;
    logic               sit_flag;
    logic               lqr_select;
    logic               apply_modes;

    modport source (output valid, output velocity_milli, output yaw_milli,
                    output walk_speed, output walk_flag, output sit_flag,
                    output lqr_select, output apply_modes, input ready);
    modport sink   (input valid, input velocity_milli, input yaw_milli,
                    input walk_speed, input walk_flag, input sit_flag,
                    input lqr_select, input apply_modes, output ready);
endinterface

// ----- src/ffd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ffd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/ffd_cell.sv -----
// ----------------------------------------------------------------------------
// Shift line cell
// Holds one byte and its valid bit; takes its neighbour's contents on a shift.
// ----------------------------------------------------------------------------
module ffd_cell
    import ffd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift_en,
    input  logic  clear,
    input  cell_t prev,
    output cell_t cur
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    // A clear drops the byte; a shift takes the neighbour's byte.
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift_en)
        begin
            valid_next = prev.valid;
            data_next  = prev.data;
        end
    end

    // The valid bit is control state and is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The byte itself needs no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign cur.valid = valid_reg;
    assign cur.data  = data_reg;

endmodule

// ----- src/ffd_match.sv -----
// ----------------------------------------------------------------------------
// Frame matcher
// Checks the window plus the new byte for a frame and decodes its fields.
// ----------------------------------------------------------------------------
module ffd_match
    import ffd_pkg::*;
(
    input  cell_t       window [KEEP_LEN],
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  start_marker,
    input  logic [7:0]  end_marker,
    output logic        found,
    output frame_t      frame
);

    logic [7:0] check_sum;
    logic [7:0] flags;

    // XOR of the six payload bytes.
    always_comb
    begin
        check_sum = 8'h00;
        for (int i = 1; i <= 6; i++)
        begin
            check_sum = check_sum ^ window[i].data;
        end
    end

    // The oldest cell only holds a byte once the window is full.
    assign found = window[0].valid
                 && (window[0].data == start_marker)
                 && (rx_byte == end_marker)
                 && (check_sum == window[KEEP_LEN-1].data);

    // Field decode: big-endian values and the flag byte.
    assign flags                = window[5].data;
    assign frame.velocity_milli = {window[1].data, window[2].data};
    assign frame.yaw_milli      = {window[3].data, window[4].data};
    assign frame.walk_speed     = window[6].data;
    assign frame.walk_flag      = flags[FLAG_WALK];
    assign frame.sit_flag       = flags[FLAG_SIT];
    assign frame.lqr_select     = flags[FLAG_LQR];
    assign frame.apply_modes    = ~flags[FLAG_SIT];

endmodule

// ----- src/fixed_frame_deframer_xor_check_top.sv -----
// ----------------------------------------------------------------------------
// Fixed frame deframer with XOR check
// Finds nine-byte frames between start and end markers and decodes them.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the frame output is free or being taken;
// a decoded frame left waiting holds off further bytes until it is taken.
// A frame appears on the output in the cycle after its closing byte is taken.
// The output register is the only stage between the byte and frame channels.
// Reset: the window empties and the markers return to 0xAA and 0x55.
// ----------------------------------------------------------------------------
module fixed_frame_deframer_xor_check_top
    import ffd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    ffd_cfg_if.sink         cfg,
    ffd_rx_if.sink          rx,
    ffd_frame_if.source     frame
);

    logic [7:0] start_marker_reg;
    logic [7:0] start_marker_next;
    logic [7:0] end_marker_reg;
    logic [7:0] end_marker_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    frame_t     out_frame_reg;
    frame_t     out_frame_next;

    cell_t      chain [KEEP_LEN+1];
    cell_t      window [KEEP_LEN];
    logic       rx_take;
    logic       found;
    frame_t     decoded;

    // Configuration writes are always taken; unknown indexes are ignored.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        start_marker_next = start_marker_reg;
        end_marker_next   = end_marker_reg;
        if (cfg.valid)
        begin
            if (cfg.index == REG_START_MARKER)
            begin
                start_marker_next = cfg.data;
            end
            else if (cfg.index == REG_END_MARKER)
            begin
                end_marker_next = cfg.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RESET;
            end_marker_reg   <= END_MARKER_RESET;
        end
        else
        begin
            start_marker_reg <= start_marker_next;
            end_marker_reg   <= end_marker_next;
        end
    end

    // A byte is taken whenever the output register is free or being drained.
    assign rx.ready = !out_valid_reg || frame.ready;
    assign rx_take  = rx.valid && rx.ready;

    // The new byte enters at the top of the shift line, newest in the last cell.
    assign chain[KEEP_LEN].valid = 1'b1;
    assign chain[KEEP_LEN].data  = rx.rx_byte;

    for (genvar g = 0; g < KEEP_LEN; g++)
    begin : g_cell
        ffd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (rx_take && !found),
            .clear    (rx_take && found),
            .prev     (chain[g+1]),
            .cur      (chain[g])
        );
        assign window[g] = chain[g];
    end

    ffd_match u_match (
        .window       (window),
        .rx_byte      (rx.rx_byte),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .found        (found),
        .frame        (decoded)
    );

    // Output register: load on a found frame, empty once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_frame_next = out_frame_reg;
        if (rx_take && found)
        begin
            out_valid_next = 1'b1;
            out_frame_next = decoded;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_frame_reg <= out_frame_next;
    end

    assign frame.valid          = out_valid_reg;
    assign frame.velocity_milli = out_frame_reg.velocity_milli;
    assign frame.yaw_milli      = out_frame_reg.yaw_milli;
    assign frame.walk_speed     = out_frame_reg.walk_speed;
    assign frame.walk_flag      = out_frame_reg.walk_flag;
    assign frame.sit_flag       = out_frame_reg.sit_flag;
    assign frame.lqr_select     = out_frame_reg.lqr_select;
    assign frame.apply_modes    = out_frame_reg.apply_modes;

endmodule
